// ===== sv/mfv_pkg.sv =====
// mfv_pkg: shared types, constants and codes of the fractional voc charger
// no dependencies
`timescale 1ns / 1ps

package mfv_pkg;

    localparam int AdcBits          = 12;
    localparam int TicksPerControl  = 10;
    localparam int TicksPerSense    = 100;
    localparam int DoneBlinkPeriods = 100;

    localparam logic [12:0] RefMax   = 13'd8191;
    localparam logic [13:0] PanelMax = 14'd16383;
    localparam logic [12:0] BattMax  = 13'd8191;

    // register indexes
    localparam logic [2:0] REG_PWM_PERIOD   = 3'd0;
    localparam logic [2:0] REG_FINISH_MV    = 3'd1;
    localparam logic [2:0] REG_FINISH_PER   = 3'd2;
    localparam logic [2:0] REG_VREF_CAL     = 3'd3;
    localparam logic [2:0] REG_RATIO_PCT    = 3'd4;
    localparam logic [2:0] REG_MIN_TARGET   = 3'd5;
    localparam logic [2:0] REG_STABLE_DIFF  = 3'd6;
    localparam logic [2:0] REG_STABLE_SAMP  = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [11:0] panel_raw;
        logic [11:0] battery_raw;
        logic [11:0] vref_raw;
    } t_in_item;

    typedef struct packed {
        logic [10:0] pwm_duty;
        logic        led_on;
        logic        charge_done;
        logic        open_sensing;
        logic [13:0] target_millivolts;
        logic [13:0] panel_millivolts;
        logic [12:0] battery_millivolts;
    } t_out_item;

endpackage

// ===== sv/mfv_front.sv =====
// mfv_front: input stage that takes items and holds them in a two entry queue
// depends on mfv_pkg
`timescale 1ns / 1ps

module mfv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  mfv_pkg::t_in_item i_item,
    output logic              o_valid,
    output mfv_pkg::t_in_item o_item,
    input  logic              i_take
);
    import mfv_pkg::*;

    t_in_item   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push_ok, w_pop_ok;

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_mem[r_rp];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_take && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) r_wp <= ~r_wp;
            if (w_pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push_ok} - {1'b0, w_pop_ok};
        end
    end
endmodule

// ===== sv/mfv_div.sv =====
// mfv_div: restoring divider, one quotient bit per cycle
// depends on mfv_pkg
`timescale 1ns / 1ps

module mfv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [11:0] i_den,
    output logic        o_busy,
    output logic [23:0] o_quot
);
    import mfv_pkg::*;

    logic [23:0] r_q;
    logic [12:0] r_rem;
    logic [11:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [12:0] w_sh;

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign w_sh   = {r_rem[11:0], r_q[23]};

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd24;
            r_q    <= i_num;
            r_rem  <= 13'd0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[22:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[22:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end
endmodule

// ===== sv/mfv_back.sv =====
// mfv_back: sequencer that carries out one item and writes its result beat
// depends on mfv_pkg, mfv_div
`timescale 1ns / 1ps

module mfv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mfv_pkg::t_in_item  i_item,
    output logic               o_take,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [13:0]        i_cfg_data,
    output logic               o_empty,
    input  logic               i_pop,
    output mfv_pkg::t_out_item o_result
);
    import mfv_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_TGT  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    // configuration
    logic [10:0] r_pwm_period;
    logic [12:0] r_finish_mv;
    logic [9:0]  r_finish_per;
    logic [11:0] r_vref_cal;
    logic [6:0]  r_ratio;
    logic [13:0] r_min_tgt;
    logic [11:0] r_diff_lim;
    logic [3:0]  r_stable_samp;

    // controller state
    logic [10:0] r_duty;
    logic [13:0] r_target, r_panel;
    logic [12:0] r_batt, r_ref;
    logic [9:0]  r_fcnt;
    logic        r_done, r_sense, r_led;
    logic [3:0]  r_stable, r_t10;
    logic [11:0] r_prev;
    logic [6:0]  r_t100, r_bper, r_bcnt;

    t_state      r_st;
    t_in_item    r_it;
    logic        r_fin;
    logic [25:0] r_pmul;
    logic [24:0] r_bmul;
    logic [20:0] r_tprod;
    logic        r_oval;
    t_out_item   r_out;

    logic        w_dstart, w_dbusy;
    logic [23:0] w_dnum, w_quot;
    logic        w_load;

    mfv_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (r_it.vref_raw),
        .o_busy (w_dbusy),
        .o_quot (w_quot)
    );

    assign o_take   = (r_st == ST_IDLE) && i_valid;
    assign o_empty  = !r_oval;
    assign o_result = r_out;
    assign w_dnum   = {12'd0, r_vref_cal} * 24'd3300;
    assign w_dstart = (r_st == ST_TGT) && !r_it.kind && (r_it.vref_raw != 12'd0);
    // result register is free, or its beat leaves at this edge
    assign w_load   = (r_st == ST_OUT) && (!r_oval || i_pop);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= 11'd1199;
            r_finish_mv   <= 13'd1450;
            r_finish_per  <= 10'd500;
            r_vref_cal    <= 12'd1530;
            r_ratio       <= 7'd83;
            r_min_tgt     <= 14'd2400;
            r_diff_lim    <= 12'd10;
            r_stable_samp <= 4'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PWM_PERIOD:  r_pwm_period  <= i_cfg_data[10:0];
                REG_FINISH_MV:   r_finish_mv   <= i_cfg_data[12:0];
                REG_FINISH_PER:  r_finish_per  <= i_cfg_data[9:0];
                REG_VREF_CAL:    r_vref_cal    <= i_cfg_data[11:0];
                REG_RATIO_PCT:   r_ratio       <= i_cfg_data[6:0];
                REG_MIN_TARGET:  r_min_tgt     <= i_cfg_data[13:0];
                REG_STABLE_DIFF: r_diff_lim    <= i_cfg_data[11:0];
                REG_STABLE_SAMP: r_stable_samp <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // next-state of the tick path, worked in one step
    logic [10:0] n_duty;
    logic [9:0]  n_fcnt;
    logic        n_done, n_sense, n_led;
    logic [3:0]  n_stable, n_t10;
    logic [6:0]  n_t100, n_bper, n_bcnt;
    logic [11:0] w_diff;
    logic        w_stab;
    logic [6:0]  w_want;

    function automatic logic [10:0] f_step(input logic [10:0] d, input logic up,
                                           input logic [10:0] per);
        logic [11:0] inc;
        inc = {1'b0, d} + 12'd1;
        if (up) f_step = (inc < {1'b0, per}) ? inc[10:0] : per;
        else    f_step = (d != 11'd0) ? d - 11'd1 : d;
    endfunction

    always_comb begin
        n_duty   = r_duty;
        n_fcnt   = r_fcnt;
        n_done   = r_done;
        n_sense  = r_sense;
        n_led    = r_led;
        n_stable = r_stable;
        n_t10    = r_t10;
        n_t100   = r_t100;
        n_bper   = r_bper;
        n_bcnt   = r_bcnt;
        w_want   = 7'd0;
        if (!r_done && !r_sense) n_duty = f_step(n_duty, r_panel > r_target, r_pwm_period);
        n_t10 = r_t10 + 4'd1;
        if (n_t10 >= 4'(TicksPerControl)) begin
            n_t10 = 4'd0;
            if (!r_sense) begin
                if (r_done) begin
                    n_duty = 11'd0;
                    w_want = 7'(DoneBlinkPeriods);
                end else begin
                    n_duty = f_step(n_duty, r_panel > r_target, r_pwm_period);
                    if (r_batt >= r_finish_mv) begin
                        if (n_fcnt != 10'd1023) n_fcnt = n_fcnt + 10'd1;
                        if (n_fcnt >= r_finish_per) n_done = 1'b1;
                    end else begin
                        n_done = 1'b0;
                        n_fcnt = 10'd0;
                    end
                end
                if (n_bper != w_want) begin
                    n_bper = w_want;
                    n_bcnt = 7'd0;
                end
                if (n_bper != 7'd0) begin
                    n_bcnt = n_bcnt + 7'd1;
                    if (n_bcnt >= n_bper) begin
                        n_led  = ~n_led;
                        n_bcnt = 7'd0;
                    end
                end else begin
                    n_bcnt = 7'd0;
                end
            end
        end
        n_t100 = r_t100 + 7'd1;
        if (n_t100 >= 7'(TicksPerSense)) begin
            n_t100   = 7'd0;
            n_sense  = 1'b1;
            n_stable = 4'd0;
        end
    end

    assign w_diff = (r_it.panel_raw > r_prev) ? r_it.panel_raw - r_prev
                                              : r_prev - r_it.panel_raw;
    assign w_stab = w_diff < r_diff_lim;

    // sample arithmetic helpers
    logic [26:0] w_pshift;
    logic [24:0] w_bshift;
    logic [13:0] w_pmv;
    logic [12:0] w_bmv;
    logic [13:0] w_tq, w_tsat;
    logic [42:0] w_tmul;

    assign w_pshift = {r_pmul, 1'b0} >> AdcBits;
    assign w_bshift = r_bmul >> AdcBits;
    assign w_pmv    = (w_pshift > 27'(PanelMax)) ? PanelMax : w_pshift[13:0];
    assign w_bmv    = (w_bshift > 25'(BattMax)) ? BattMax : w_bshift[12:0];
    // divide by 100 by reciprocal: ceil(2^28/100) exact for 21-bit values
    assign w_tmul   = {22'd0, r_tprod} * 43'd2684355;
    assign w_tq     = w_tmul[42] ? PanelMax : w_tmul[41:28];
    assign w_tsat   = w_tq;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_oval   <= 1'b0;
            r_duty   <= 11'd0;
            r_target <= 14'd0;
            r_panel  <= 14'd0;
            r_batt   <= 13'd0;
            r_ref    <= 13'd0;
            r_fcnt   <= 10'd0;
            r_done   <= 1'b0;
            r_sense  <= 1'b0;
            r_led    <= 1'b0;
            r_stable <= 4'd0;
            r_prev   <= 12'd0;
            r_t10    <= 4'd0;
            r_t100   <= 7'd0;
            r_bper   <= 7'd0;
            r_bcnt   <= 7'd0;
        end else begin
            if (w_load) r_oval <= 1'b1;
            else if (i_pop && r_oval) r_oval <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (o_take) begin
                        r_it <= i_item;
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_it.kind) begin
                        r_duty   <= n_duty;
                        r_fcnt   <= n_fcnt;
                        r_done   <= n_done;
                        r_sense  <= n_sense;
                        r_led    <= n_led;
                        r_stable <= n_stable;
                        r_t10    <= n_t10;
                        r_t100   <= n_t100;
                        r_bper   <= n_bper;
                        r_bcnt   <= n_bcnt;
                        r_st     <= ST_OUT;
                    end else begin
                        r_pmul <= {14'd0, r_it.panel_raw} * {13'd0, r_ref};
                        r_bmul <= {13'd0, r_it.battery_raw} * {12'd0, r_ref};
                        r_fin  <= 1'b0;
                        if (r_sense) begin
                            if (w_stab) begin
                                if (r_stable >= r_stable_samp) r_fin <= 1'b1;
                                else r_stable <= r_stable + 4'd1;
                            end else begin
                                r_stable <= 4'd0;
                            end
                            if (!(w_stab && r_stable >= r_stable_samp))
                                r_prev <= r_it.panel_raw;
                        end
                        r_st <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    r_tprod <= {7'd0, w_pmv} * {14'd0, r_ratio};
                    r_batt  <= w_bmv;
                    if (!r_sense) r_panel <= w_pmv;
                    if (r_it.vref_raw == 12'd0) r_ref <= RefMax;
                    r_st <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_fin) begin
                        r_target <= (w_tsat < r_min_tgt) ? r_min_tgt : w_tsat;
                        r_sense  <= 1'b0;
                        r_fin    <= 1'b0;
                    end
                    if (!w_dbusy && !w_dstart) begin
                        if (r_it.vref_raw != 12'd0)
                            r_ref <= (w_quot > 24'(RefMax)) ? RefMax : w_quot[12:0];
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_out.pwm_duty <= (r_sense || r_done) ? 11'd0 :
                            ((r_duty < r_pwm_period) ? r_duty : r_pwm_period);
                        r_out.led_on             <= (r_bper != 7'd0) && r_led;
                        r_out.charge_done        <= r_done;
                        r_out.open_sensing       <= r_sense;
                        r_out.target_millivolts  <= r_target;
                        r_out.panel_millivolts   <= r_panel;
                        r_out.battery_millivolts <= r_batt;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/mppt_fractional_voc_charger.sv =====
// mppt_fractional_voc_charger: top level of the fractional voc charge controller
// depends on mfv_pkg, mfv_front, mfv_back
//
//  channel  | handshake    | payload
//  input    | push / full  | i_item  (kind, panel_raw, battery_raw, vref_raw)
//  result   | pop / empty  | o_result (duty, led, done, sensing, millivolts)
//  config   | i_cfg_we     | i_cfg_idx, i_cfg_data
//
// a tick beat passes the back sequencer through idle, mul and out; a sample
// beat also passes tgt and div, where the 24-step serial divider works the
// reference update; a sample with a zero reference reading skips the divider.
// reset is synchronous, active low, and clears all control state.
// the next beat is worked while a result waits; its own result holds in the
// last step until the waiting one is popped. a two entry queue takes input.
`timescale 1ns / 1ps

module mppt_fractional_voc_charger (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mfv_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mfv_pkg::t_out_item o_result,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [13:0]        i_cfg_data
);
    import mfv_pkg::*;

    logic     w_valid, w_take;
    t_in_item w_item;

    mfv_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_item (i_item),
        .o_valid(w_valid),
        .o_item (w_item),
        .i_take (w_take)
    );

    mfv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_item    (w_item),
        .o_take    (w_take),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );
endmodule
